>>> rtl/bse_pkg.sv
// Bucket sort engine: shared package.
// Holds the value width, parameter defaults, controller states, datapath
// operations and the status struct. No dependencies.
package bse_pkg;

  localparam int VALUE_BITS = 16;
  localparam int MAX_ITEMS_DEF = 64;
  localparam int BUCKETS_DEF = 16;

  typedef enum logic [4:0] {
    S_LOAD,
    S_CLR,
    S_CNT_RD,
    S_CNT_BK,
    S_CNT_WR,
    S_PFX_RD,
    S_PFX_WR,
    S_DST_RD,
    S_DST_BK,
    S_DST_WR,
    S_SRT_BK,
    S_SRT_END,
    S_SRT_J,
    S_SRT_KEY,
    S_SRT_CMP,
    S_SRT_PUT,
    S_EMIT,
    S_DRAIN
  } state_t;

  typedef enum logic [4:0] {
    OP_LOAD,
    OP_CLR,
    OP_CNT_RD,
    OP_CNT_BK,
    OP_CNT_WR,
    OP_PFX_RD,
    OP_PFX_WR,
    OP_DST_RD,
    OP_DST_BK,
    OP_DST_WR,
    OP_SRT_BK,
    OP_SRT_END,
    OP_SRT_J,
    OP_SRT_KEY,
    OP_SRT_CMP,
    OP_SRT_PUT,
    OP_EMIT,
    OP_DRAIN
  } op_t;

  typedef struct packed {
    logic last_load;  // request with last_item taken this cycle
    logic b_last;     // bucket index at final bucket
    logic k_last;     // item index at final item
    logic seg_done;   // insertion pass reached end of bucket
    logic shift;      // neighbor greater than key
    logic more;       // shift position still above bucket start
  } status_t;

endpackage

>>> rtl/bucket_sort_engine.sv
// Bucket sort engine: top level.
// Joins bse_ctrl and bse_datapath; uses bse_pkg.
//
// Usage: a request (value_in, last_item) is taken at a rising edge where
// start is high and busy is low. Values are Q0.16 fractions and load one per
// cycle into the item store; loads past MAX_ITEMS are dropped and remembered.
// The request with last_item set ends the set (it is stored if room is left)
// and busy rises. The engine then clears the bucket counters, counts items per
// bucket (bucket = value * BUCKETS >> 16), turns counts into start offsets,
// distributes items into the sorted store and insertion-sorts each bucket.
// Results follow in ascending order, one per cycle, each shown for exactly
// one cycle with result_strobe high; the final one carries last_out, and
// overflow is the same on every result of the set. The receiver cannot stall.
// The stores are single-port and are walked one access per step. busy falls
// the cycle after the last result. Reset empties the set and returns the
// engine to loading; store contents are not cleared.
module bucket_sort_engine #(
  parameter int MAX_ITEMS = bse_pkg::MAX_ITEMS_DEF,
  parameter int BUCKETS   = bse_pkg::BUCKETS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [bse_pkg::VALUE_BITS-1:0] value_in,
  input  logic                           last_item,
  output logic                           result_strobe,
  output logic [bse_pkg::VALUE_BITS-1:0] sorted_value,
  output logic                           last_out,
  output logic                           overflow
);

  bse_pkg::op_t     cmd;
  bse_pkg::status_t status;

  bse_ctrl u_ctrl (
    .clk(clk), .rst(rst), .status(status), .cmd(cmd), .busy(busy)
  );

  bse_datapath #(.MAX_ITEMS(MAX_ITEMS), .BUCKETS(BUCKETS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .start(start), .value_in(value_in),
    .last_item(last_item), .status(status), .result_strobe(result_strobe),
    .sorted_value(sorted_value), .last_out(last_out), .overflow(overflow)
  );

endmodule

>>> rtl/bse_ram.sv
// Bucket sort engine: generic single-port-write, single-port-read RAM.
// Registered read data. No dependencies.
module bse_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/bse_ctrl.sv
// Bucket sort engine: controller state machine.
// Sequences load, count, prefix, distribute, sort and emit; uses bse_pkg.
module bse_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  bse_pkg::status_t status,
  output bse_pkg::op_t     cmd,
  output logic             busy
);

  bse_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bse_pkg::S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      bse_pkg::S_LOAD:    if (status.last_load) state_next = bse_pkg::S_CLR;
      bse_pkg::S_CLR:     if (status.b_last) state_next = bse_pkg::S_CNT_RD;
      bse_pkg::S_CNT_RD:  state_next = bse_pkg::S_CNT_BK;
      bse_pkg::S_CNT_BK:  state_next = bse_pkg::S_CNT_WR;
      bse_pkg::S_CNT_WR:  state_next = status.k_last ? bse_pkg::S_PFX_RD : bse_pkg::S_CNT_RD;
      bse_pkg::S_PFX_RD:  state_next = bse_pkg::S_PFX_WR;
      bse_pkg::S_PFX_WR:  state_next = status.b_last ? bse_pkg::S_DST_RD : bse_pkg::S_PFX_RD;
      bse_pkg::S_DST_RD:  state_next = bse_pkg::S_DST_BK;
      bse_pkg::S_DST_BK:  state_next = bse_pkg::S_DST_WR;
      bse_pkg::S_DST_WR:  state_next = status.k_last ? bse_pkg::S_SRT_BK : bse_pkg::S_DST_RD;
      bse_pkg::S_SRT_BK:  state_next = bse_pkg::S_SRT_END;
      bse_pkg::S_SRT_END: state_next = bse_pkg::S_SRT_J;
      bse_pkg::S_SRT_J: begin
        if (status.seg_done) begin
          state_next = status.b_last ? bse_pkg::S_EMIT : bse_pkg::S_SRT_BK;
        end else begin
          state_next = bse_pkg::S_SRT_KEY;
        end
      end
      bse_pkg::S_SRT_KEY: state_next = bse_pkg::S_SRT_CMP;
      bse_pkg::S_SRT_CMP: begin
        if (status.shift) begin
          state_next = status.more ? bse_pkg::S_SRT_CMP : bse_pkg::S_SRT_PUT;
        end else begin
          state_next = bse_pkg::S_SRT_J;
        end
      end
      bse_pkg::S_SRT_PUT: state_next = bse_pkg::S_SRT_J;
      bse_pkg::S_EMIT:    if (status.k_last) state_next = bse_pkg::S_DRAIN;
      bse_pkg::S_DRAIN:   state_next = bse_pkg::S_LOAD;
      default:            state_next = bse_pkg::S_LOAD;
    endcase
  end

  always_comb begin
    busy = 1'b1;
    cmd  = bse_pkg::OP_LOAD;
    case (state)
      bse_pkg::S_LOAD: begin
        busy = 1'b0;
        cmd  = bse_pkg::OP_LOAD;
      end
      bse_pkg::S_CLR:     cmd = bse_pkg::OP_CLR;
      bse_pkg::S_CNT_RD:  cmd = bse_pkg::OP_CNT_RD;
      bse_pkg::S_CNT_BK:  cmd = bse_pkg::OP_CNT_BK;
      bse_pkg::S_CNT_WR:  cmd = bse_pkg::OP_CNT_WR;
      bse_pkg::S_PFX_RD:  cmd = bse_pkg::OP_PFX_RD;
      bse_pkg::S_PFX_WR:  cmd = bse_pkg::OP_PFX_WR;
      bse_pkg::S_DST_RD:  cmd = bse_pkg::OP_DST_RD;
      bse_pkg::S_DST_BK:  cmd = bse_pkg::OP_DST_BK;
      bse_pkg::S_DST_WR:  cmd = bse_pkg::OP_DST_WR;
      bse_pkg::S_SRT_BK:  cmd = bse_pkg::OP_SRT_BK;
      bse_pkg::S_SRT_END: cmd = bse_pkg::OP_SRT_END;
      bse_pkg::S_SRT_J:   cmd = bse_pkg::OP_SRT_J;
      bse_pkg::S_SRT_KEY: cmd = bse_pkg::OP_SRT_KEY;
      bse_pkg::S_SRT_CMP: cmd = bse_pkg::OP_SRT_CMP;
      bse_pkg::S_SRT_PUT: cmd = bse_pkg::OP_SRT_PUT;
      bse_pkg::S_EMIT:    cmd = bse_pkg::OP_EMIT;
      bse_pkg::S_DRAIN:   cmd = bse_pkg::OP_DRAIN;
      default: begin
        busy = 1'b1;
        cmd  = bse_pkg::OP_DRAIN;
      end
    endcase
  end

endmodule

>>> rtl/bse_datapath.sv
// Bucket sort engine: datapath with item store, bucket counters and
// sorted store. Uses bse_pkg and bse_ram.
module bse_datapath #(
  parameter int MAX_ITEMS = bse_pkg::MAX_ITEMS_DEF,
  parameter int BUCKETS   = bse_pkg::BUCKETS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  bse_pkg::op_t                   cmd,
  input  logic                           start,
  input  logic [bse_pkg::VALUE_BITS-1:0] value_in,
  input  logic                           last_item,
  output bse_pkg::status_t               status,
  output logic                           result_strobe,
  output logic [bse_pkg::VALUE_BITS-1:0] sorted_value,
  output logic                           last_out,
  output logic                           overflow
);

  localparam int VB  = bse_pkg::VALUE_BITS;
  localparam int AW  = $clog2(MAX_ITEMS);
  localparam int CW  = $clog2(MAX_ITEMS + 1);
  localparam int JW  = CW + 1;
  localparam int BW  = $clog2(BUCKETS);
  localparam int BCW = $clog2(BUCKETS + 1);
  localparam int PW  = VB + BCW;

  logic [CW-1:0]  count;
  logic           ovf;
  logic [CW-1:0]  k;
  logic [BCW-1:0] bidx;
  logic [CW-1:0]  acc;
  logic [CW-1:0]  seg_end;
  logic [JW-1:0]  j;
  logic [JW-1:0]  i;
  logic [VB-1:0]  key;
  logic [VB-1:0]  item_val;
  logic [BW-1:0]  bkt;
  logic           emit_v;
  logic           emit_last;

  logic           i_we;
  logic [AW-1:0]  i_waddr, i_raddr;
  logic [VB-1:0]  i_rdata;
  logic           s_we;
  logic [AW-1:0]  s_waddr, s_raddr;
  logic [VB-1:0]  s_wdata, s_rdata;
  logic           f_we;
  logic [BW-1:0]  f_waddr, f_raddr;
  logic [CW-1:0]  f_wdata, f_rdata;

  logic [PW-1:0]  prod;
  logic [BW-1:0]  bkt_rd;
  logic [JW-1:0]  i_m1, i_m2;
  logic           b_last, k_last, seg_done, shift, more, room;

  bse_ram #(.WIDTH(VB), .DEPTH(MAX_ITEMS)) u_item_ram (
    .clk(clk), .we(i_we), .waddr(i_waddr), .wdata(value_in),
    .raddr(i_raddr), .rdata(i_rdata)
  );

  bse_ram #(.WIDTH(VB), .DEPTH(MAX_ITEMS)) u_sorted_ram (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  bse_ram #(.WIDTH(CW), .DEPTH(BUCKETS)) u_fill_ram (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .raddr(f_raddr), .rdata(f_rdata)
  );

  // bucket = (value * BUCKETS) >> VALUE_BITS
  assign prod   = PW'(i_rdata) * PW'(BUCKETS);
  assign bkt_rd = prod[VB +: BW];

  assign i_m1     = i - JW'(1);
  assign i_m2     = i - JW'(2);
  assign room     = (count < CW'(MAX_ITEMS));
  assign b_last   = (bidx == BCW'(BUCKETS - 1));
  assign k_last   = ((k + CW'(1)) == count);
  assign seg_done = (j >= {1'b0, seg_end});
  assign shift    = (s_rdata > key);
  assign more     = (i_m1 > {1'b0, acc});

  always_comb begin
    status.last_load = (cmd == bse_pkg::OP_LOAD) && start && last_item;
    status.b_last    = b_last;
    status.k_last    = k_last;
    status.seg_done  = seg_done;
    status.shift     = shift;
    status.more      = more;
  end

  always_comb begin
    i_we    = 1'b0;
    i_waddr = count[AW-1:0];
    i_raddr = k[AW-1:0];
    s_we    = 1'b0;
    s_waddr = i[AW-1:0];
    s_wdata = key;
    s_raddr = k[AW-1:0];
    f_we    = 1'b0;
    f_waddr = bkt;
    f_wdata = f_rdata + CW'(1);
    f_raddr = bidx[BW-1:0];
    case (cmd)
      bse_pkg::OP_LOAD:   i_we = start && room;
      bse_pkg::OP_CLR: begin
        f_we    = 1'b1;
        f_waddr = bidx[BW-1:0];
        f_wdata = '0;
      end
      bse_pkg::OP_CNT_BK: f_raddr = bkt_rd;
      bse_pkg::OP_CNT_WR: f_we = 1'b1;
      bse_pkg::OP_PFX_WR: begin
        f_we    = 1'b1;
        f_waddr = bidx[BW-1:0];
        f_wdata = acc;
      end
      bse_pkg::OP_DST_BK: f_raddr = bkt_rd;
      bse_pkg::OP_DST_WR: begin
        f_we    = 1'b1;
        s_we    = 1'b1;
        s_waddr = f_rdata[AW-1:0];
        s_wdata = item_val;
      end
      bse_pkg::OP_SRT_J:   s_raddr = j[AW-1:0];
      bse_pkg::OP_SRT_KEY: s_raddr = i_m1[AW-1:0];
      bse_pkg::OP_SRT_CMP: begin
        s_we = 1'b1;
        if (shift) begin
          s_wdata = s_rdata;
          s_raddr = i_m2[AW-1:0];
        end
      end
      bse_pkg::OP_SRT_PUT: s_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      ovf    <= 1'b0;
      emit_v <= 1'b0;
    end else begin
      emit_v <= (cmd == bse_pkg::OP_EMIT);
      case (cmd)
        bse_pkg::OP_LOAD: begin
          if (start) begin
            if (room) begin
              count <= count + CW'(1);
            end else begin
              ovf <= 1'b1;
            end
          end
        end
        bse_pkg::OP_DRAIN: begin
          count <= '0;
          ovf   <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd)
      bse_pkg::OP_LOAD: bidx <= '0;
      bse_pkg::OP_CLR: begin
        bidx <= bidx + BCW'(1);
        k    <= '0;
      end
      bse_pkg::OP_CNT_BK: bkt <= bkt_rd;
      bse_pkg::OP_CNT_WR: begin
        k    <= k_last ? '0 : k + CW'(1);
        bidx <= '0;
        acc  <= '0;
      end
      bse_pkg::OP_PFX_WR: begin
        bidx <= b_last ? '0 : bidx + BCW'(1);
        acc  <= b_last ? '0 : acc + f_rdata;
      end
      bse_pkg::OP_DST_BK: begin
        item_val <= i_rdata;
        bkt      <= bkt_rd;
      end
      bse_pkg::OP_DST_WR: k <= k_last ? '0 : k + CW'(1);
      bse_pkg::OP_SRT_END: begin
        seg_end <= f_rdata;
        j       <= {1'b0, acc} + JW'(1);
      end
      bse_pkg::OP_SRT_J: begin
        i <= j;
        if (seg_done) begin
          acc  <= seg_end;
          bidx <= bidx + BCW'(1);
        end
      end
      bse_pkg::OP_SRT_KEY: key <= s_rdata;
      bse_pkg::OP_SRT_CMP: begin
        if (shift) begin
          i <= i_m1;
        end else begin
          j <= j + JW'(1);
        end
      end
      bse_pkg::OP_SRT_PUT: j <= j + JW'(1);
      bse_pkg::OP_EMIT: begin
        k         <= k_last ? '0 : k + CW'(1);
        emit_last <= k_last;
      end
      default: ;
    endcase
  end

  assign result_strobe = emit_v;
  assign sorted_value  = s_rdata;
  assign last_out      = emit_last;
  assign overflow      = ovf;

endmodule

>>> rtl/bse_checker.sv
// Bucket sort engine: port-level checker and its bind to the top level.
// Depends on bucket_sort_engine.
module bse_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic last_item,
  input logic result_strobe,
  input logic last_out,
  input logic overflow
);

  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> busy)
    else $error("result shown while idle");

  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && last_item |=> busy)
    else $error("end of set did not start sorting");

  a_stream: assert property (@(posedge clk) disable iff (rst)
    result_strobe && !last_out |=> result_strobe && $stable(overflow))
    else $error("gap or overflow change in result stream");

  a_end: assert property (@(posedge clk) disable iff (rst)
    result_strobe && last_out |=> !result_strobe)
    else $error("result after final result");

  a_release: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> $past(result_strobe && last_out))
    else $error("busy fell without final result");

endmodule

bind bucket_sort_engine bse_checker u_bse_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy),
  .last_item(last_item), .result_strobe(result_strobe),
  .last_out(last_out), .overflow(overflow)
);
